/* hdl/bqat_pkg.sv */
package bqat_pkg;

    localparam int DEF_NUM_SLOTS  = 256;
    localparam int DEF_USAGE_BITS = 32;

    localparam int CMD_W   = 3;
    localparam int ID_W    = 8;
    localparam int AMT_W   = 32;
    localparam int FLAG_W  = 32;
    localparam int CNT_W   = 32;
    localparam int OUT_W   = 32;
    localparam int TALLY_W = 9;

    // bit positions in a slot's state flag entry
    localparam int LIVE_BIT  = 1;
    localparam int DIRTY_BIT = 0;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE     = 3'd0,
        CMD_DESTROY    = 3'd1,
        CMD_ALLOC      = 3'd2,
        CMD_DEALLOC    = 3'd3,
        CMD_QUERY      = 3'd4,
        CMD_MARK_DIRTY = 3'd5,
        CMD_PROCESS    = 3'd6,
        CMD_NOP        = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_LIMIT     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SWEEP
    } back_state_t;

    // classified request, as it travels from the front part to the back part
    typedef struct packed {
        cmd_t              op;
        logic              addressed;
        logic [ID_W-1:0]   id;
        logic [AMT_W-1:0]  amount;
        logic [FLAG_W-1:0] flags;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    assigned_id;
        logic [OUT_W-1:0]   usage_now;
        logic [OUT_W-1:0]   usage_peak;
        logic [OUT_W-1:0]   usage_limit;
        logic [OUT_W-1:0]   live_allocations;
        logic [OUT_W-1:0]   account_flags;
        logic               account_live;
        logic [TALLY_W-1:0] processed_count;
        logic [TALLY_W-1:0] accounts_created;
    } res_t;

endpackage

/* hdl/bqat_front.sv */
module bqat_front
    import bqat_pkg::*;
(
    input  logic              in_valid,
    input  logic [CMD_W-1:0]  command,
    input  logic [ID_W-1:0]   tracker_id,
    input  logic [AMT_W-1:0]  amount,
    input  logic [FLAG_W-1:0] create_flags,
    input  logic              q_full,
    output logic              in_stall,
    output logic              push,
    output req_t              push_req
);

    cmd_t op;
    logic addressed;

    assign op = cmd_t'(command);

    // commands that name an existing slot
    always_comb
    begin
        unique case (op)
            CMD_DESTROY, CMD_ALLOC, CMD_DEALLOC, CMD_QUERY, CMD_MARK_DIRTY: addressed = 1'b1;
            default: addressed = 1'b0;
        endcase
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign push_req.op        = op;
    assign push_req.addressed = addressed;
    assign push_req.id        = tracker_id;
    assign push_req.amount    = amount;
    assign push_req.flags     = create_flags;

endmodule

/* hdl/bqat_queue.sv */
module bqat_queue
    import bqat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output req_t head
);

    localparam int DEPTH  = 2;
    localparam int QCNT_W = 2;

    req_t              store_reg [DEPTH];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* hdl/bqat_back.sv */
module bqat_back
    import bqat_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int USAGE_BITS = DEF_USAGE_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_not_empty,
    input  req_t q_head,
    output logic pop,
    output logic out_valid,
    input  logic out_stall,
    output res_t res
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NS_W   = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = (NS_W > ID_W) ? NS_W : ID_W;
    localparam int SUM_W  = ((USAGE_BITS > AMT_W) ? USAGE_BITS : AMT_W) + 1;

    typedef struct packed {
        logic [USAGE_BITS-1:0] limit;
        logic [USAGE_BITS-1:0] usage;
        logic [USAGE_BITS-1:0] peak;
        logic [CNT_W-1:0]      count;
        logic [FLAG_W-1:0]     flags;
    } acct_t;

    // slot storage; entries at or past next_slot are never looked at
    logic [1:0] flag_mem [NUM_SLOTS];
    acct_t      acct_mem [NUM_SLOTS];

    back_state_t state_reg;
    back_state_t state_next;
    req_t        req_reg;
    req_t        req_next;
    logic [NS_W-1:0]   next_slot_reg;
    logic [NS_W-1:0]   next_slot_next;
    logic [NS_W-1:0]   sweep_idx_reg;
    logic [NS_W-1:0]   sweep_idx_next;
    logic [NS_W-1:0]   proc_cnt_reg;
    logic [NS_W-1:0]   proc_cnt_next;
    logic              chk_valid_reg;
    logic              chk_valid_next;
    logic [SLOT_W-1:0] chk_addr_reg;
    logic [SLOT_W-1:0] chk_addr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              res_reg;
    res_t              res_next;
    logic [1:0]        rd_flag_reg;
    acct_t             rd_acct_reg;

    logic [SLOT_W-1:0] rd_addr;
    logic              flag_we;
    logic [SLOT_W-1:0] flag_wa;
    logic [1:0]        flag_wd;
    logic              acct_we;
    logic [SLOT_W-1:0] acct_wa;
    acct_t             acct_wd;

    logic              known;
    logic              live;
    logic [SLOT_W-1:0] id_slot;
    logic [SLOT_W-1:0] new_slot;
    logic [NS_W-1:0]   slot_inc;
    logic [SUM_W-1:0]  amt_ext;
    logic [SUM_W-1:0]  usage_ext;
    logic [SUM_W-1:0]  sum_ext;
    logic [SUM_W-1:0]  limit_ext;
    logic [USAGE_BITS-1:0] sum_u;
    logic              over;

    assign known     = (CMP_W'(req_reg.id) < CMP_W'(next_slot_reg));
    assign live      = known && rd_flag_reg[LIVE_BIT];
    assign id_slot   = SLOT_W'(req_reg.id);
    assign new_slot  = next_slot_reg[SLOT_W-1:0];
    assign slot_inc  = next_slot_reg + NS_W'(1);
    assign amt_ext   = SUM_W'(req_reg.amount);
    assign usage_ext = SUM_W'(rd_acct_reg.usage);
    assign limit_ext = SUM_W'(rd_acct_reg.limit);
    assign sum_ext   = usage_ext + amt_ext;
    assign sum_u     = sum_ext[USAGE_BITS-1:0];
    assign over      = (sum_ext[SUM_W-1:USAGE_BITS] != '0)
                    || ((rd_acct_reg.limit != '0) && (sum_ext > limit_ext));

    assign pop       = (state_reg == BK_IDLE) && q_not_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = pop ? q_head : req_reg;
        next_slot_next = next_slot_reg;
        sweep_idx_next = sweep_idx_reg;
        proc_cnt_next  = proc_cnt_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        rd_addr        = SLOT_W'(q_head.id);
        flag_we        = 1'b0;
        flag_wa        = id_slot;
        flag_wd        = rd_flag_reg;
        acct_we        = 1'b0;
        acct_wa        = id_slot;
        acct_wd        = rd_acct_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    state_next = BK_EXEC;
                end
            end

            BK_EXEC:
            begin
                res_next                  = '0;
                res_next.status           = ST_OK;
                res_next.account_live     = req_reg.addressed && live;
                res_next.accounts_created = TALLY_W'(next_slot_reg);
                out_valid_next            = 1'b1;
                state_next                = BK_IDLE;

                unique case (req_reg.op)
                    CMD_CREATE:
                    begin
                        if (next_slot_reg == NS_W'(NUM_SLOTS))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            flag_we       = 1'b1;
                            flag_wa       = new_slot;
                            flag_wd       = 2'b11;
                            acct_we       = 1'b1;
                            acct_wa       = new_slot;
                            acct_wd.limit = USAGE_BITS'(req_reg.amount);
                            acct_wd.usage = '0;
                            acct_wd.peak  = '0;
                            acct_wd.count = '0;
                            acct_wd.flags = req_reg.flags;
                            next_slot_next            = slot_inc;
                            res_next.assigned_id      = ID_W'(next_slot_reg);
                            res_next.account_live     = 1'b1;
                            res_next.accounts_created = TALLY_W'(slot_inc);
                        end
                    end

                    CMD_DESTROY:
                    begin
                        if (!live)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            flag_we = 1'b1;
                            flag_wd[LIVE_BIT] = 1'b0;
                            acct_we = 1'b1;
                            acct_wd.usage = '0;
                            acct_wd.count = '0;
                        end
                    end

                    CMD_ALLOC:
                    begin
                        if (!live)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else if (over)
                        begin
                            res_next.status = ST_LIMIT;
                        end
                        else
                        begin
                            flag_we = 1'b1;
                            flag_wd[DIRTY_BIT] = 1'b1;
                            acct_we = 1'b1;
                            acct_wd.usage = sum_u;
                            if (sum_u > rd_acct_reg.peak)
                            begin
                                acct_wd.peak = sum_u;
                            end
                            if (rd_acct_reg.count != '1)
                            begin
                                acct_wd.count = rd_acct_reg.count + CNT_W'(1);
                            end
                        end
                    end

                    CMD_DEALLOC:
                    begin
                        if (!live)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            flag_we = 1'b1;
                            flag_wd[DIRTY_BIT] = 1'b1;
                            acct_we = 1'b1;
                            // clamp over-free at zero
                            if (usage_ext < amt_ext)
                            begin
                                acct_wd.usage = '0;
                            end
                            else
                            begin
                                acct_wd.usage = USAGE_BITS'(usage_ext - amt_ext);
                            end
                            if (rd_acct_reg.count != '0)
                            begin
                                acct_wd.count = rd_acct_reg.count - CNT_W'(1);
                            end
                        end
                    end

                    CMD_QUERY:
                    begin
                        if (!live)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            res_next.usage_now        = OUT_W'(rd_acct_reg.usage);
                            res_next.usage_peak       = OUT_W'(rd_acct_reg.peak);
                            res_next.usage_limit      = OUT_W'(rd_acct_reg.limit);
                            res_next.live_allocations = OUT_W'(rd_acct_reg.count);
                            res_next.account_flags    = OUT_W'(rd_acct_reg.flags);
                        end
                    end

                    CMD_MARK_DIRTY:
                    begin
                        if (!known)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            flag_we = 1'b1;
                            flag_wd[DIRTY_BIT] = 1'b1;
                        end
                    end

                    CMD_PROCESS:
                    begin
                        // hold the result until the walk is done
                        out_valid_next = 1'b0;
                        res_next       = res_reg;
                        sweep_idx_next = '0;
                        proc_cnt_next  = '0;
                        state_next     = BK_SWEEP;
                    end

                    CMD_NOP:
                    begin
                    end
                endcase
            end

            BK_SWEEP:
            begin
                // check the slot read last cycle, clear its dirty bit if it is live
                if (chk_valid_reg && rd_flag_reg[LIVE_BIT] && rd_flag_reg[DIRTY_BIT])
                begin
                    flag_we       = 1'b1;
                    flag_wa       = chk_addr_reg;
                    flag_wd       = 2'b10;
                    proc_cnt_next = proc_cnt_reg + NS_W'(1);
                end
                if (sweep_idx_reg < next_slot_reg)
                begin
                    rd_addr        = sweep_idx_reg[SLOT_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_addr_next  = sweep_idx_reg[SLOT_W-1:0];
                    sweep_idx_next = sweep_idx_reg + NS_W'(1);
                end
                else if (!chk_valid_reg)
                begin
                    res_next                  = '0;
                    res_next.status           = ST_OK;
                    res_next.processed_count  = TALLY_W'(proc_cnt_reg);
                    res_next.accounts_created = TALLY_W'(next_slot_reg);
                    out_valid_next            = 1'b1;
                    state_next                = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            next_slot_reg <= '0;
            sweep_idx_reg <= '0;
            proc_cnt_reg  <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_slot_reg <= next_slot_next;
            sweep_idx_reg <= sweep_idx_next;
            proc_cnt_reg  <= proc_cnt_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        chk_addr_reg <= chk_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wa] <= flag_wd;
        end
        rd_flag_reg <= flag_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (acct_we)
        begin
            acct_mem[acct_wa] <= acct_wd;
        end
        rd_acct_reg <= acct_mem[rd_addr];
    end

endmodule

/* hdl/budget_quota_accounting_table.sv */
// Budget quota accounting table. Each command transfer on the input channel
// gives exactly one result transfer on the output channel, in order. Accounts
// are handed out from slot 0 upward and never reused; create fails with
// status table full once NUM_SLOTS slots are gone. An accepted command waits
// in a two-entry queue, then takes two steps in the back part: the pop reads
// the addressed slot from memory with a registered read, then the execute
// state updates the slot and loads the result register. The slot memories
// have one read port and one write port; the process pending walk reads one
// slot while it writes back the one before. The back part pops the next
// command only when idle and its last result is taken. Process pending walks
// slots 0 up to accounts_created - 1, one slot per cycle. Slot state lives in
// memories with no reset; the count of slots handed out tells which entries
// hold data, so no clearing pass is needed and commands are taken right after
// reset.
module budget_quota_accounting_table
    import bqat_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int USAGE_BITS = DEF_USAGE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [ID_W-1:0]    tracker_id,
    input  logic [AMT_W-1:0]   amount,
    input  logic [FLAG_W-1:0]  create_flags,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [ID_W-1:0]    assigned_id,
    output logic [OUT_W-1:0]   usage_now,
    output logic [OUT_W-1:0]   usage_peak,
    output logic [OUT_W-1:0]   usage_limit,
    output logic [OUT_W-1:0]   live_allocations,
    output logic [OUT_W-1:0]   account_flags,
    output logic               account_live,
    output logic [TALLY_W-1:0] processed_count,
    output logic [TALLY_W-1:0] accounts_created
);

    logic push;
    req_t push_req;
    logic q_full;
    logic q_not_empty;
    req_t q_head;
    logic pop;
    res_t res;

    // classify the incoming command and push it into the queue
    bqat_front u_front
    (
        .in_valid     (in_valid),
        .command      (command),
        .tracker_id   (tracker_id),
        .amount       (amount),
        .create_flags (create_flags),
        .q_full       (q_full),
        .in_stall     (in_stall),
        .push         (push),
        .push_req     (push_req)
    );

    // decouple acceptance from execution
    bqat_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // execute against slot memory and hold the result until transferred
    bqat_back #(
        .NUM_SLOTS  (NUM_SLOTS),
        .USAGE_BITS (USAGE_BITS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res         (res)
    );

    assign status           = res.status;
    assign assigned_id      = res.assigned_id;
    assign usage_now        = res.usage_now;
    assign usage_peak       = res.usage_peak;
    assign usage_limit      = res.usage_limit;
    assign live_allocations = res.live_allocations;
    assign account_flags    = res.account_flags;
    assign account_live     = res.account_live;
    assign processed_count  = res.processed_count;
    assign accounts_created = res.accounts_created;

endmodule
